// ----- hdl/skd_pkg.sv -----
package skd_pkg;

    localparam logic [1:0] KIND_PRESS   = 2'd0;
    localparam logic [1:0] KIND_RELEASE = 2'd1;
    localparam logic [1:0] KIND_GROUP   = 2'd2;
    localparam logic [1:0] KIND_COMMAND = 2'd3;

    localparam logic [7:0] BYTE_RESET   = 8'hff;
    localparam logic [7:0] BYTE_LAYOUT  = 8'hfe;
    localparam logic [7:0] BYTE_IDLE    = 8'h7f;
    localparam logic [7:0] BYTE_ERROR   = 8'h7e;
    localparam logic [7:0] BYTE_NULL    = 8'h00;
    localparam logic [7:0] BYTE_NULL_HI = 8'h80;

    localparam logic [7:0] CMD_RESET     = 8'd1;
    localparam logic [7:0] CMD_CLICK_OFF = 8'd11;

    localparam int NUM_GROUPS = 4;

    typedef enum logic [1:0] {
        PH_NONE         = 2'd0,
        PH_WANT_RESET   = 2'd1,
        PH_WANT_DECLICK = 2'd2
    } t_phase;

    typedef struct packed {
        logic                               key_vld;
        logic                               key_rel;
        logic [6:0]                         key_code;
        logic                               idle_vld;
        logic [NUM_GROUPS-1:0][31:0]        grp_mask;
        logic                               cmd_vld;
        logic [7:0]                         cmd;
    } t_dec;

endpackage

// ----- hdl/skd_decode.sv -----
module skd_decode (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic [7:0]    i_byte,
    input  logic          i_fire,
    output skd_pkg::t_dec o_dec
);

    logic [skd_pkg::NUM_GROUPS-1:0][31:0] r_held, n_held;
    logic                                 r_skip, n_skip;
    skd_pkg::t_phase                      r_phase, n_phase;
    logic [7:0]                           key_m1;

    assign key_m1 = i_byte - 8'd1;

    always_comb begin
        n_held  = r_held;
        n_skip  = r_skip;
        n_phase = r_phase;
        o_dec   = '0;
        if (r_skip) begin
            n_skip = 1'b0;
        end else begin
            unique case (i_byte) inside
                skd_pkg::BYTE_RESET: begin
                    n_skip  = 1'b1;
                    n_phase = skd_pkg::PH_WANT_DECLICK;
                end
                skd_pkg::BYTE_LAYOUT: begin
                    n_skip = 1'b1;
                end
                skd_pkg::BYTE_IDLE: begin
                    o_dec.idle_vld = 1'b1;
                    o_dec.grp_mask = r_held;
                    o_dec.cmd_vld  = (r_phase == skd_pkg::PH_WANT_RESET) ||
                                     (r_phase == skd_pkg::PH_WANT_DECLICK);
                    o_dec.cmd      = (r_phase == skd_pkg::PH_WANT_RESET) ?
                                     skd_pkg::CMD_RESET : skd_pkg::CMD_CLICK_OFF;
                    n_held         = '0;
                    n_phase        = skd_pkg::PH_NONE;
                end
                skd_pkg::BYTE_ERROR, skd_pkg::BYTE_NULL, skd_pkg::BYTE_NULL_HI: begin
                end
                default: begin
                    o_dec.key_vld  = 1'b1;
                    o_dec.key_rel  = key_m1[7];
                    o_dec.key_code = key_m1[6:0];
                    n_held[key_m1[6:5]][key_m1[4:0]] = ~key_m1[7];
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_held  <= '0;
            r_skip  <= 1'b0;
            r_phase <= skd_pkg::PH_WANT_RESET;
        end else if (i_fire) begin
            r_held  <= n_held;
            r_skip  <= n_skip;
            r_phase <= n_phase;
        end
    end

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_fire && o_dec.idle_vld) |=> (r_held == '0) && (r_phase == skd_pkg::PH_NONE))
        else $error("idle byte left keys held or a command armed");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_dec.key_vld && o_dec.idle_vld))
        else $error("byte decoded as both key and idle");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skip |-> (o_dec == '0))
        else $error("skipped byte produced a result");

endmodule

// ----- hdl/skd_emit.sv -----
module skd_emit (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_fire,
    input  skd_pkg::t_dec i_dec,
    input  logic          i_out_ready,
    output logic          o_can_take,
    output logic          o_valid,
    output logic [1:0]    o_kind,
    output logic [6:0]    o_key_code,
    output logic [1:0]    o_group_index,
    output logic [31:0]   o_group_mask,
    output logic [7:0]    o_command,
    output logic          o_last
);

    logic [skd_pkg::NUM_GROUPS-1:0]       r_gvld;
    logic [skd_pkg::NUM_GROUPS-1:0][31:0] r_gmask;
    logic                                 r_cvld;
    logic [7:0]                           r_cmd;
    logic                                 r_out_valid;
    logic [1:0]                           r_kind;
    logic [6:0]                           r_key_code;
    logic [1:0]                           r_group_index;
    logic [31:0]                          r_group_mask;
    logic [7:0]                           r_command;
    logic                                 r_last;

    logic                                 adv;
    logic                                 pend_any;
    logic                                 head_gv;
    logic [1:0]                           head_g;
    logic [skd_pkg::NUM_GROUPS-1:0]       rest_g;

    assign adv        = !r_out_valid || i_out_ready;
    assign pend_any   = (|r_gvld) || r_cvld;
    assign o_can_take = !pend_any && adv;

    always_comb begin
        head_g  = 2'd0;
        head_gv = 1'b0;
        for (int g = 0; g < skd_pkg::NUM_GROUPS; g++) begin
            if (r_gvld[g]) begin
                head_g  = g[1:0];
                head_gv = 1'b1;
            end
        end
        rest_g = r_gvld & ~(4'b0001 << head_g);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gvld      <= '0;
            r_cvld      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (adv) begin
                if (head_gv) begin
                    r_out_valid     <= 1'b1;
                    r_kind          <= skd_pkg::KIND_GROUP;
                    r_key_code      <= '0;
                    r_group_index   <= head_g;
                    r_group_mask    <= r_gmask[head_g];
                    r_command       <= '0;
                    r_last          <= (rest_g == '0) && !r_cvld;
                    r_gvld[head_g]  <= 1'b0;
                end else if (r_cvld) begin
                    r_out_valid     <= 1'b1;
                    r_kind          <= skd_pkg::KIND_COMMAND;
                    r_key_code      <= '0;
                    r_group_index   <= '0;
                    r_group_mask    <= '0;
                    r_command       <= r_cmd;
                    r_last          <= 1'b1;
                    r_cvld          <= 1'b0;
                end else if (i_fire && i_dec.key_vld) begin
                    r_out_valid     <= 1'b1;
                    r_kind          <= i_dec.key_rel ? skd_pkg::KIND_RELEASE
                                                     : skd_pkg::KIND_PRESS;
                    r_key_code      <= i_dec.key_code;
                    r_group_index   <= '0;
                    r_group_mask    <= '0;
                    r_command       <= '0;
                    r_last          <= 1'b1;
                end else begin
                    r_out_valid     <= 1'b0;
                end
            end
            if (i_fire && i_dec.idle_vld) begin
                for (int g = 0; g < skd_pkg::NUM_GROUPS; g++) begin
                    r_gvld[g] <= (i_dec.grp_mask[g] != '0);
                end
                r_gmask <= i_dec.grp_mask;
                r_cvld  <= i_dec.cmd_vld;
                r_cmd   <= i_dec.cmd;
            end
        end
    end

    assign o_valid       = r_out_valid;
    assign o_kind        = r_kind;
    assign o_key_code    = r_key_code;
    assign o_group_index = r_group_index;
    assign o_group_mask  = r_group_mask;
    assign o_command     = r_command;
    assign o_last        = r_last;

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_fire |-> !pend_any)
        else $error("new byte taken while results still pending");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_kind == skd_pkg::KIND_COMMAND) |-> r_last)
        else $error("command result not marked last");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_kind == skd_pkg::KIND_GROUP) |-> (r_group_mask != '0))
        else $error("empty group mask emitted");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_fire |=> $countones(r_gvld) <= $countones($past(r_gvld)))
        else $error("pending groups grew without a new byte");

endmodule

// ----- hdl/serial_keyboard_scancode_decoder.sv -----
// Serial keyboard byte decoder.
// Input channel: i_valid / o_ready carry one received byte on i_rx_byte per beat.
// Output channel: o_valid / i_ready carry one result per beat: o_kind selects
// key press, key release, released group mask or command byte; o_last marks the
// final result of a byte. Fields that do not apply to a kind read as zero.
// A key byte passes the input and then the result register. An idle byte passes
// the input register and pending group and command registers, then gives one
// result per cycle while i_ready is high, up to five (four group masks, highest
// group first, then a command). Throughput: one key byte per cycle while i_ready
// is high; the input register stalls while an idle byte's pending results drain
// from the result register. Skipped, reset, layout and ignored bytes give no
// result. Reset clears the held-key map and arms a keyboard reset command, sent
// at the first idle byte. When the receiver stalls, the result register holds and
// the input register fills, then o_ready drops; no beat is lost.
module serial_keyboard_scancode_decoder (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [7:0]  i_rx_byte,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [1:0]  o_kind,
    output logic [6:0]  o_key_code,
    output logic [1:0]  o_group_index,
    output logic [31:0] o_group_mask,
    output logic [7:0]  o_command,
    output logic        o_last
);

    logic          r_in_valid;
    logic [7:0]    r_in_byte;
    logic          can_take;
    logic          fire;
    skd_pkg::t_dec dec;

    assign fire    = r_in_valid && can_take;
    assign o_ready = !r_in_valid || fire;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
            r_in_byte  <= '0;
        end else if (o_ready) begin
            r_in_valid <= i_valid;
            r_in_byte  <= i_rx_byte;
        end
    end

    skd_decode u_decode (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_byte  (r_in_byte),
        .i_fire  (fire),
        .o_dec   (dec)
    );

    skd_emit u_emit (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_fire        (fire),
        .i_dec         (dec),
        .i_out_ready   (i_ready),
        .o_can_take    (can_take),
        .o_valid       (o_valid),
        .o_kind        (o_kind),
        .o_key_code    (o_key_code),
        .o_group_index (o_group_index),
        .o_group_mask  (o_group_mask),
        .o_command     (o_command),
        .o_last        (o_last)
    );

endmodule
